// ===== hw/rtl/isort_pkg.sv =====
// isort_pkg: shared constants and types of the insertion sorter
// used by the stream interfaces, the controller, the datapath and the top level
// no dependencies
package isort_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [31:0] value_t;
	typedef logic [CNT_W-1:0]   count_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic insert;
		logic pop;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic last_one;
	} status_t;

endpackage

// ===== hw/rtl/isort_stream_if.sv =====
// isort_item_if, isort_res_if: valid/ready channels of the insertion sorter
// depends on isort_pkg
interface isort_item_if import isort_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;
	logic   last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface isort_res_if import isort_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value_res;
	logic   last_res;
	logic   overflow;

	modport source (output valid, output value_res, output last_res, output overflow,
		input ready);
	modport sink (input valid, input value_res, input last_res, input overflow,
		output ready);
endinterface

// ===== hw/rtl/insertion_sorter.sv =====
// insertion_sorter: top level, stable ascending sort of signed 32-bit values
// depends on isort_pkg, isort_stream_if, isort_ctrl, isort_dp
//
// Items enter on the items channel (value, last) and results leave on the
// results channel (value_res, last_res, overflow), both valid/ready; a
// transaction happens on a clock edge with valid and ready high.
// While filling, one item is taken per cycle: a row of DEPTH compare-and-shift
// cells places each value as it is taken, after any equal values.
// The item with last set is inserted too, and the next cycle the first result
// is valid; results then leave one per cycle from cell 0 while the receiver
// takes them, one result per stored value (at most DEPTH).
// No item is taken while a batch drains. If the receiver stalls, the head
// result holds steady until it is taken.
// Items arriving with DEPTH values stored are dropped and overflow is set on
// every result of that batch; last_res marks the final result.
// After reset the store is empty and in_ready is low until its register is set.
module insertion_sorter import isort_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	isort_item_if.sink         items,
	isort_res_if.source        results
);

	cmd_t    cmd;
	status_t status;

	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	isort_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_value     (items.value),
		.out_value    (results.value_res),
		.out_last     (results.last_res),
		.out_overflow (results.overflow),
		.status       (status)
	);

endmodule

// ===== hw/rtl/isort_ctrl.sv =====
// isort_ctrl: fill/drain state machine of the insertion sorter
// drives the channel handshakes and the datapath commands; depends on isort_pkg
module isort_ctrl import isort_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready   = in_ready_q;
	assign out_valid  = out_valid_q;
	assign cmd.insert = in_valid && in_ready_q;
	assign cmd.pop    = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (in_valid && in_ready_q && in_last) begin
						state_q     <= ST_DRAIN;
						in_ready_q  <= 1'b0;
						out_valid_q <= 1'b1;
					end else begin
						in_ready_q <= 1'b1;
					end
				end
				ST_DRAIN: begin
					// the final transaction of the batch empties the store
					if (out_valid_q && out_ready && status.last_one) begin
						state_q     <= ST_FILL;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_FILL;
					in_ready_q  <= 1'b0;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready_q && out_valid_q))
		else $error("input and output open at the same time");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready_q && in_last) |=> out_valid_q)
		else $error("last item did not start the drain");

	a_drain_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !status.empty)
		else $error("draining an empty store");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && status.last_one) |=> (!out_valid_q && in_ready_q))
		else $error("drain did not end after the final result");

endmodule

// ===== hw/rtl/isort_dp.sv =====
// isort_dp: row of compare-and-shift cells holding the sorted values
// inserts one value per cycle, shifts toward cell 0 on pop; depends on isort_pkg
module isort_dp import isort_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  value_t  in_value,
	output value_t  out_value,
	output logic    out_last,
	output logic    out_overflow,
	output status_t status
);

	value_t           store_q [DEPTH];
	count_t           count_q;
	logic             dropped_q;
	logic [DEPTH-1:0] gt;
	logic             full;
	logic             do_insert;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_insert = cmd.insert && !full;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   shift_in;
		logic   take_v;
		value_t lower;
		value_t upper;

		// entry is occupied and strictly greater, so equal values stay ahead
		assign gt[i] = (CNT_W'(i) < count_q) && (store_q[i] > in_value);

		if (i == 0) begin : g_first
			assign shift_in = 1'b0;
			assign lower    = in_value;
		end else begin : g_inner
			assign shift_in = gt[i-1];
			assign lower    = store_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign upper = store_q[i];
		end else begin : g_mid
			assign upper = store_q[i+1];
		end

		assign take_v = (gt[i] || (count_q == CNT_W'(i))) && !shift_in;

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (shift_in) begin
					store_q[i] <= lower;
				end else if (take_v) begin
					store_q[i] <= in_value;
				end
			end else if (cmd.pop) begin
				store_q[i] <= upper;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	assign out_value       = store_q[0];
	assign out_last        = (count_q == CNT_W'(1));
	assign out_overflow    = dropped_q;
	assign status.empty    = (count_q == '0);
	assign status.last_one = (count_q == CNT_W'(1));

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the store");

	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && !cmd.insert && count_q == CNT_W'(1)) |=> (count_q == '0 && !dropped_q))
		else $error("store not cleared after the final result");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (store_q[0] <= store_q[1]))
		else $error("head of the store out of order");

endmodule

// ===== test/isort_checker.sv =====
`timescale 1ns / 1ps
// isort_checker: watches both channels of the insertion sorter, keeps its own sorted
// store per batch and compares every result transaction; depends on isort_pkg and
// the isort_item_if / isort_res_if interfaces
module isort_checker import isort_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	isort_item_if items,
	isort_res_if  results,
	output int    failures,
	output int    results_due,
	output int    results_seen,
	output int    batches_done,
	output int    overflow_batches
);

	typedef struct packed {
		value_t value;
		logic   last;
		logic   overflow;
	} sorted_res_t;

	value_t      batch_store[$];
	logic        batch_dropped = 1'b0;
	sorted_res_t sorted_due[$];
	sorted_res_t want;
	sorted_res_t held_res;
	logic        held = 1'b0;
	int          fail_count = 0;
	int          due_count = 0;
	int          seen_count = 0;
	int          batch_count = 0;
	int          ovf_count = 0;

	assign failures         = fail_count;
	assign results_due      = due_count;
	assign results_seen     = seen_count;
	assign batches_done     = batch_count;
	assign overflow_batches = ovf_count;

	task automatic check_field(input string name, input logic signed [63:0] expected,
		input logic signed [63:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			fail_count++;
		end
	endtask

	// stable insert: a new value goes after every stored value equal to it
	task automatic insert_sorted(input value_t v, input logic closes_batch);
		int          pos;
		sorted_res_t r;
		pos = batch_store.size();
		if (pos >= DEPTH) begin
			batch_dropped = 1'b1;
		end else begin
			while (pos > 0 && batch_store[pos-1] > v)
				pos--;
			batch_store.insert(pos, v);
		end
		if (closes_batch) begin
			foreach (batch_store[k]) begin
				r.value    = batch_store[k];
				r.last     = (k == batch_store.size() - 1);
				r.overflow = batch_dropped;
				sorted_due.push_back(r);
			end
			batch_count++;
			if (batch_dropped)
				ovf_count++;
			batch_store.delete();
			batch_dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_store.delete();
			sorted_due.delete();
			batch_dropped = 1'b0;
			held = 1'b0;
			due_count = 0;
		end else begin
			// a stalled result must hold still until it is taken
			if (held) begin
				check_field("valid while stalled", 1, results.valid);
				check_field("value_res while stalled", held_res.value, results.value_res);
				check_field("last_res while stalled", held_res.last, results.last_res);
				check_field("overflow while stalled", held_res.overflow, results.overflow);
			end
			held = results.valid && !results.ready;
			held_res.value    = results.value_res;
			held_res.last     = results.last_res;
			held_res.overflow = results.overflow;

			if (results.valid && results.ready) begin
				seen_count++;
				if (sorted_due.size() == 0) begin
					$error("value_res: expected no transaction, got %0d", results.value_res);
					fail_count++;
				end else begin
					want = sorted_due.pop_front();
					check_field("value_res", want.value, results.value_res);
					check_field("last_res", want.last, results.last_res);
					check_field("overflow", want.overflow, results.overflow);
				end
			end

			if (items.valid && items.ready)
				insert_sorted(items.value, items.last);
			due_count = sorted_due.size();
		end
	end

endmodule

// ===== test/insertion_sorter_test.sv =====
`timescale 1ns / 1ps
// insertion_sorter_test: drives batches of signed values into insertion_sorter with
// random stalls on both sides; checking is done by isort_checker
// depends on isort_pkg, the stream interfaces, insertion_sorter and isort_checker
module insertion_sorter_test;
	import isort_pkg::*;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	int     send_idle = 34;
	int     recv_idle = 57;
	int     items_sent = 0;
	int     phase_items;
	int     failures;
	int     results_due;
	int     results_seen;
	int     batches_done;
	int     overflow_batches;
	value_t mixed_set[$]   = '{5, -3, 5, 32'sh80000000, 32'sh7fffffff, 0, -1, 1, 5, -3};
	value_t falling_set[$] = '{3, 2, 1, 0, -1};
	value_t equal_set[$]   = '{7, 7, 7};

	isort_item_if items();
	isort_res_if  results();

	insertion_sorter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	isort_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.items            (items),
		.results          (results),
		.failures         (failures),
		.results_due      (results_due),
		.results_seen     (results_seen),
		.batches_done     (batches_done),
		.overflow_batches (overflow_batches)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		results.ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(input value_t v, input logic closes_batch);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			items.valid <= 1'b0;
			items.value <= $urandom;
			@(negedge clk);
		end
		items.valid <= 1'b1;
		items.value <= v;
		items.last  <= closes_batch;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		items_sent++;
		phase_items++;
	endtask

	task automatic send_set(input value_t set_values[$]);
		foreach (set_values[k])
			send_item(set_values[k], k == set_values.size() - 1);
	endtask

	// many small values give plenty of duplicates, the rest spans the full range
	function automatic value_t pick_value();
		case ($urandom_range(3))
			0: begin
				return $urandom_range(8) - 4;
			end
			1: begin
				return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(2)
					: 32'sh80000000 + $urandom_range(2);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_batch(input int n);
		for (int k = 0; k < n; k++)
			send_item(pick_value(), k == n - 1);
	endtask

	// sender goes quiet until the last sorted result has been taken
	task automatic drain_results();
		@(negedge clk);
		items.valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	initial begin
		items.valid   = 1'b0;
		items.value   = '0;
		items.last    = 1'b0;
		results.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one-item batches at both extremes, then mixed, falling and all-equal sets
		send_item(32'sh7fffffff, 1'b1);
		send_item(32'sh80000000, 1'b1);
		send_set(mixed_set);
		send_set(falling_set);
		send_set(equal_set);
		drain_results();

		for (int p = 0; p < 3; p++) begin
			send_idle = (p == 0) ? 34 : (p == 1) ? 57 : 0;
			recv_idle = (p == 0) ? 57 : (p == 1) ? 34 : 0;
			phase_items = 0;
			while (phase_items < 15)
				send_batch($urandom_range(12, 1));
			// full store: drops before the last and a dropped last value, then exactly full
			if (p == 0)
				send_batch(DEPTH + 2);
			else if (p == 1)
				send_batch(DEPTH);
			drain_results();
		end

		repeat (20) @(negedge clk);
		$display("sent %0d items in %0d batches, %0d of them with dropped values",
			items_sent, batches_done, overflow_batches);
		$display("checked %0d sorted results under sender and receiver stalls",
			results_seen);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
